### design/cartesian_to_polar_range_rate_core_defines.svh
// Assertion macros for the cartesian to polar range rate core.
`ifndef CARTESIAN_TO_POLAR_RANGE_RATE_CORE_DEFINES_SVH
`define CARTESIAN_TO_POLAR_RANGE_RATE_CORE_DEFINES_SVH

// Property that holds whenever the condition is met, outside reset.
`define C2P_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Property that holds in the cycle after the condition, outside reset.
`define C2P_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/c2p_pkg.sv
// ----------------------------------------------------------------------------
// c2p_pkg
// Shared constants and the arctangent table of the cartesian to polar core.
// ----------------------------------------------------------------------------
package c2p_pkg;

  localparam int CORDIC_STAGES = 24;
  localparam int SQRT_LAT      = 32;
  localparam int DIV_LAT       = 33;
  localparam int CORDIC_LAT    = CORDIC_STAGES + 2;
  localparam int BEAR_DELAY    = SQRT_LAT + 1 + DIV_LAT - CORDIC_LAT;
  localparam int TOTAL_LAT     = SQRT_LAT + 1 + DIV_LAT;

  localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [33:0] PI_Q29      = 34'sd1686629713;

  // atan(2^-i) in Q2.30, truncated.
  function automatic logic signed [33:0] atan_q30(input int i);
    logic signed [33:0] v;
    case (i)
      0:  v = 34'sd843314856;
      1:  v = 34'sd497837829;
      2:  v = 34'sd263043836;
      3:  v = 34'sd133525158;
      4:  v = 34'sd67021686;
      5:  v = 34'sd33543515;
      6:  v = 34'sd16775850;
      7:  v = 34'sd8388437;
      8:  v = 34'sd4194282;
      9:  v = 34'sd2097149;
      10: v = 34'sd1048575;
      11: v = 34'sd524287;
      12: v = 34'sd262143;
      13: v = 34'sd131071;
      14: v = 34'sd65535;
      15: v = 34'sd32767;
      16: v = 34'sd16383;
      17: v = 34'sd8191;
      18: v = 34'sd4095;
      19: v = 34'sd2047;
      20: v = 34'sd1023;
      21: v = 34'sd511;
      22: v = 34'sd255;
      23: v = 34'sd127;
      24: v = 34'sd63;
      25: v = 34'sd31;
      26: v = 34'sd15;
      27: v = 34'sd7;
      28: v = 34'sd3;
      29: v = 34'sd1;
      default: v = 34'sd0;
    endcase
    return v;
  endfunction

endpackage

### design/c2p_isqrt.sv
// ----------------------------------------------------------------------------
// c2p_isqrt
// Pipelined square root of a 64-bit value, one result bit per stage.
// ----------------------------------------------------------------------------
module c2p_isqrt (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [63:0] sum_i,
  output logic [31:0] root_o,
  output logic        inexact_o
);

  localparam int N = c2p_pkg::SQRT_LAT;

  logic [35:0] rem_q  [N];
  logic [31:0] root_q [N];
  logic [63:0] s_q    [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [35:0] rem_in, cand, trial;
    logic [31:0] root_in;
    logic [63:0] s_in;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign s_in    = sum_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign s_in    = s_q[k-1];
    end

    assign cand  = {rem_in[33:0], s_in[63:62]};
    assign trial = {2'b00, root_in, 2'b01};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        s_q[k] <= {s_in[61:0], 2'b00};
        if (cand >= trial) begin
          rem_q[k]  <= cand - trial;
          root_q[k] <= {root_in[30:0], 1'b1};
        end else begin
          rem_q[k]  <= cand;
          root_q[k] <= {root_in[30:0], 1'b0};
        end
      end
    end
  end

  assign root_o    = root_q[N-1];
  assign inexact_o = |rem_q[N-1];

endmodule

### design/c2p_div.sv
// ----------------------------------------------------------------------------
// c2p_div
// Pipelined restoring divider: 64-bit dividend by 32-bit divisor, 33-bit
// quotient, one quotient bit per stage.
// ----------------------------------------------------------------------------
module c2p_div (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [63:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic [32:0] quot_o
);

  localparam int N = c2p_pkg::DIV_LAT;

  logic [32:0] rem_q  [N];
  logic [32:0] dvd_q  [N];
  logic [31:0] dsr_q  [N];
  logic [32:0] quot_q [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [32:0] rem_in, dvd_in, quot_in, cand;
    logic [31:0] dsr_in;

    if (k == 0) begin : g_first
      // The quotient always fits in 33 bits, so the top bits stay below the divisor.
      assign rem_in  = {2'b00, dividend_i[63:33]};
      assign dvd_in  = dividend_i[32:0];
      assign dsr_in  = divisor_i;
      assign quot_in = '0;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign dvd_in  = dvd_q[k-1];
      assign dsr_in  = dsr_q[k-1];
      assign quot_in = quot_q[k-1];
    end

    assign cand = {rem_in[31:0], dvd_in[32]};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dvd_q[k] <= {dvd_in[31:0], 1'b0};
        dsr_q[k] <= dsr_in;
        if (cand >= {1'b0, dsr_in}) begin
          rem_q[k]  <= cand - {1'b0, dsr_in};
          quot_q[k] <= {quot_in[31:0], 1'b1};
        end else begin
          rem_q[k]  <= cand;
          quot_q[k] <= {quot_in[31:0], 1'b0};
        end
      end
    end
  end

  assign quot_o = quot_q[N-1];

endmodule

### design/c2p_cordic.sv
// ----------------------------------------------------------------------------
// c2p_cordic
// Pipelined vectoring CORDIC giving atan2(y, x) in Q3.29 radians.
// ----------------------------------------------------------------------------
module c2p_cordic (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [31:0] px_i,
  input  logic signed [31:0] py_i,
  output logic signed [31:0] bearing_o
);

  localparam int N = c2p_pkg::CORDIC_STAGES;

  logic signed [63:0] x0_q, y0_q;
  logic signed [33:0] z0_q;
  logic               zero0_q;

  logic signed [63:0] x_q [N];
  logic signed [63:0] y_q [N];
  logic signed [33:0] z_q [N];
  logic               zero_q [N];

  logic signed [63:0] xs, ys;
  logic signed [33:0] zr;
  logic signed [31:0] bearing_q;

  assign xs = 64'(px_i) <<< 29;
  assign ys = 64'(py_i) <<< 29;

  // Vectors in the left half plane are turned by a quarter turn first.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zero0_q <= (px_i == '0) && (py_i == '0);
      if (xs < 0) begin
        if (ys >= 0) begin
          x0_q <= ys;
          y0_q <= -xs;
          z0_q <= c2p_pkg::HALF_PI_Q30;
        end else begin
          x0_q <= -ys;
          y0_q <= xs;
          z0_q <= -c2p_pkg::HALF_PI_Q30;
        end
      end else begin
        x0_q <= xs;
        y0_q <= ys;
        z0_q <= '0;
      end
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic signed [63:0] x_in, y_in;
    logic signed [33:0] z_in;
    logic               zero_in;

    if (i == 0) begin : g_first
      assign x_in    = x0_q;
      assign y_in    = y0_q;
      assign z_in    = z0_q;
      assign zero_in = zero0_q;
    end else begin : g_next
      assign x_in    = x_q[i-1];
      assign y_in    = y_q[i-1];
      assign z_in    = z_q[i-1];
      assign zero_in = zero_q[i-1];
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        zero_q[i] <= zero_in;
        if (y_in > 0) begin
          x_q[i] <= x_in + (y_in >>> i);
          y_q[i] <= y_in - (x_in >>> i);
          z_q[i] <= z_in + c2p_pkg::atan_q30(i);
        end else begin
          x_q[i] <= x_in - (y_in >>> i);
          y_q[i] <= y_in + (x_in >>> i);
          z_q[i] <= z_in - c2p_pkg::atan_q30(i);
        end
      end
    end
  end

  assign zr = (z_q[N-1] + 34'sd1) >>> 1;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (zero_q[N-1]) begin
        bearing_q <= '0;
      end else if (zr > c2p_pkg::PI_Q29) begin
        bearing_q <= c2p_pkg::PI_Q29[31:0];
      end else if (zr < -c2p_pkg::PI_Q29) begin
        bearing_q <= 32'(-c2p_pkg::PI_Q29);
      end else begin
        bearing_q <= zr[31:0];
      end
    end
  end

  assign bearing_o = bearing_q;

endmodule

### design/cartesian_to_polar_range_rate_core.sv
// ----------------------------------------------------------------------------
// cartesian_to_polar_range_rate_core
// Range, bearing and range rate of a tracked object from its Q16.16 state.
// ----------------------------------------------------------------------------
// The core accepts one state every cycle while the output side is not stalled
// and passes each one through the operand, product and sum registers, a
// 32-stage square root, one clamp stage, a 33-stage divider and the output
// register. The CORDIC bearing runs in parallel and is delayed to line up.
// A stall on the output holds the whole pipeline.
`include "cartesian_to_polar_range_rate_core_defines.svh"

module cartesian_to_polar_range_rate_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [16:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] vel_x_i,
  input  logic signed [31:0] vel_y_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [31:0]        range_o,
  output logic signed [31:0] bearing_o,
  output logic signed [32:0] range_rate_o
);

  localparam int SQ  = c2p_pkg::SQRT_LAT;
  localparam int DV  = c2p_pkg::DIV_LAT;
  localparam int BD  = c2p_pkg::BEAR_DELAY;
  localparam int TOT = c2p_pkg::TOTAL_LAT;

  logic               en;
  logic [16:0]        min_range_q;
  logic               v1_q, v2_q, v3_q;
  logic [TOT-1:0]     vld_q;
  logic               out_valid_q;

  logic signed [31:0] px1_q, py1_q, vx1_q, vy1_q;
  logic signed [31:0] px2_q, py2_q;
  logic [31:0]        apx, apy, avx, avy;
  logic [63:0]        sqx_q, sqy_q, m1_q, m2_q;
  logic               n1_q, n2_q;
  logic [63:0]        sum_q, mag_q;
  logic               neg_q;
  logic signed [31:0] px3_q, py3_q;

  logic [31:0]        root;
  logic               inexact;
  logic [64:0]        md_q [SQ];
  logic [31:0]        rceil, floor_r;
  logic [31:0]        r4_q;
  logic [63:0]        mag4_q;
  logic               neg4_q;
  logic [32:0]        rd_q [DV];
  logic [32:0]        quot;
  logic signed [31:0] bear;
  logic signed [31:0] bd_q [BD];

  logic [31:0]        range_q;
  logic signed [31:0] bearing_q;
  logic signed [32:0] rr_q;

  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_range_q <= 17'd1;
    end else if (cfg_we_i) begin
      min_range_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v1_q        <= in_valid_i;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      vld_q       <= {vld_q[TOT-2:0], v3_q};
      out_valid_q <= vld_q[TOT-1];
    end
  end

  assign apx = pos_x_i[31] ? 32'(-pos_x_i) : pos_x_i;
  assign apy = pos_y_i[31] ? 32'(-pos_y_i) : pos_y_i;
  assign avx = vel_x_i[31] ? 32'(-vel_x_i) : vel_x_i;
  assign avy = vel_y_i[31] ? 32'(-vel_y_i) : vel_y_i;

  // Stage one holds magnitudes, stage two the products, stage three the sums.
  logic [31:0] apx1_q, apy1_q, avx1_q, avy1_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      px1_q  <= pos_x_i;
      py1_q  <= pos_y_i;
      vx1_q  <= vel_x_i;
      vy1_q  <= vel_y_i;
      apx1_q <= apx;
      apy1_q <= apy;
      avx1_q <= avx;
      avy1_q <= avy;

      px2_q <= px1_q;
      py2_q <= py1_q;
      sqx_q <= 64'(apx1_q) * 64'(apx1_q);
      sqy_q <= 64'(apy1_q) * 64'(apy1_q);
      m1_q  <= 64'(apx1_q) * 64'(avx1_q);
      m2_q  <= 64'(apy1_q) * 64'(avy1_q);
      n1_q  <= (apx1_q != '0) && (avx1_q != '0) && (px1_q[31] != vx1_q[31]);
      n2_q  <= (apy1_q != '0) && (avy1_q != '0) && (py1_q[31] != vy1_q[31]);

      px3_q <= px2_q;
      py3_q <= py2_q;
      sum_q <= sqx_q + sqy_q;
      if (n1_q == n2_q) begin
        mag_q <= m1_q + m2_q;
        neg_q <= n1_q;
      end else if (m1_q >= m2_q) begin
        mag_q <= m1_q - m2_q;
        neg_q <= n1_q;
      end else begin
        mag_q <= m2_q - m1_q;
        neg_q <= n2_q;
      end
    end
  end

  c2p_isqrt u_isqrt (
    .clk_i     (clk_i),
    .en_i      (en),
    .sum_i     (sum_q),
    .root_o    (root),
    .inexact_o (inexact)
  );

  c2p_cordic u_cordic (
    .clk_i     (clk_i),
    .en_i      (en),
    .px_i      (px3_q),
    .py_i      (py3_q),
    .bearing_o (bear)
  );

  assign rceil   = root + {31'd0, inexact};
  assign floor_r = (min_range_q == '0) ? 32'd1 : {15'd0, min_range_q};

  always_ff @(posedge clk_i) begin
    if (en) begin
      md_q[0] <= {neg_q, mag_q};
      for (int i = 1; i < SQ; i++) begin
        md_q[i] <= md_q[i-1];
      end
      r4_q   <= (rceil < floor_r) ? floor_r : rceil;
      mag4_q <= md_q[SQ-1][63:0];
      neg4_q <= md_q[SQ-1][64];
      rd_q[0] <= {neg4_q, r4_q};
      for (int i = 1; i < DV; i++) begin
        rd_q[i] <= rd_q[i-1];
      end
      bd_q[0] <= bear;
      for (int i = 1; i < BD; i++) begin
        bd_q[i] <= bd_q[i-1];
      end
    end
  end

  c2p_div u_div (
    .clk_i      (clk_i),
    .en_i       (en),
    .dividend_i (mag4_q),
    .divisor_i  (r4_q),
    .quot_o     (quot)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      range_q   <= rd_q[DV-1][31:0];
      bearing_q <= bd_q[BD-1];
      rr_q      <= rd_q[DV-1][32] ? 33'(-quot) : quot;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign range_o      = range_q;
  assign bearing_o    = bearing_q;
  assign range_rate_o = rr_q;

  `C2P_ASSERT_IMPL(a_range_floor, out_valid_o, range_o != '0, "range below one LSB")
  `C2P_ASSERT_IMPL(a_bearing_bound, out_valid_o,
                   (bearing_o <= 32'sd1686629713) && (bearing_o >= -32'sd1686629713),
                   "bearing outside minus pi to pi")
  `C2P_ASSERT_NEXT(a_stall_hold, out_valid_o && !out_ready_i, $stable(vld_q),
                   "pipeline moved during an output stall")

endmodule
